// ===== hw/rtl/sms_pkg.sv =====
package sms_pkg;

    // Status / mode codes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_PUSHING   = 3'd1;
    localparam logic [2:0] MODE_PUSHED    = 3'd2;
    localparam logic [2:0] MODE_RELEASING = 3'd3;
    localparam logic [2:0] MODE_RELEASED  = 3'd4;
    localparam logic [2:0] MODE_FAULT     = 3'd5;

    // Command codes
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_STOP        = 3'd1;
    localparam logic [2:0] ACT_PUSH        = 3'd2;
    localparam logic [2:0] ACT_RELEASE     = 3'd3;
    localparam logic [2:0] ACT_FAULT_RESET = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_PUSH_SPEED          = 3'd0;
    localparam logic [2:0] REG_RELEASE_SPEED       = 3'd1;
    localparam logic [2:0] REG_PUSH_TIME_LIMIT     = 3'd2;
    localparam logic [2:0] REG_RELEASE_TIME_LIMIT  = 3'd3;
    localparam logic [2:0] REG_FAULT_CURRENT_LIMIT = 3'd4;
    localparam logic [2:0] REG_PUSH_MIN_TIME       = 3'd5;
    localparam logic [2:0] REG_PUSH_EXTRA_TIME     = 3'd6;
    localparam logic [2:0] REG_RELEASE_MIN_TIME    = 3'd7;

    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_REV = 1'b1;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic        pushed_sensor;
        logic        released_sensor;
        logic [11:0] current_sample;
    } t_poll;

    typedef struct packed {
        logic [2:0]  status;
        logic        power_enable;
        logic [9:0]  in1_high_duty;
        logic        in2_level;
        logic        safe_phase;
        logic [11:0] peak_current;
    } t_result;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [15:0] push_speed;
        logic [15:0] release_speed;
        logic [15:0] push_time_limit;
        logic [15:0] release_time_limit;
        logic [11:0] fault_current_limit;
        logic [15:0] push_min_time;
        logic [15:0] push_extra_time;
        logic [15:0] release_min_time;
    } t_cfg;

    // Sequencer state apart from the drive speed, whose width follows PWM_MAX
    typedef struct packed {
        logic [2:0]  mode;
        logic        sensor_latched;
        logic [31:0] push_start;
        logic [31:0] sensor_seen_time;
        logic [31:0] release_start;
        logic [11:0] peak;
        logic        reverse_dir;
        logic        power_on;
    } t_state;

endpackage

// ===== hw/rtl/sms_chan_if.sv =====
interface sms_chan_if #(
    parameter type T_DATA = logic
);
    logic  valid;
    logic  ready;
    T_DATA data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sms_cfg.sv =====
module sms_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sms_chan_if.sink          i_cfg,
    output sms_pkg::t_cfg     o_regs
);

    sms_pkg::t_cfg r_regs;

    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.push_speed          <= 16'd500;
            r_regs.release_speed       <= 16'd500;
            r_regs.push_time_limit     <= 16'd5000;
            r_regs.release_time_limit  <= 16'd5000;
            r_regs.fault_current_limit <= 12'd4095;
            r_regs.push_min_time       <= 16'd200;
            r_regs.push_extra_time     <= 16'd300;
            r_regs.release_min_time    <= 16'd200;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                sms_pkg::REG_PUSH_SPEED:          r_regs.push_speed <= i_cfg.data.data;
                sms_pkg::REG_RELEASE_SPEED:       r_regs.release_speed <= i_cfg.data.data;
                sms_pkg::REG_PUSH_TIME_LIMIT:     r_regs.push_time_limit <= i_cfg.data.data;
                sms_pkg::REG_RELEASE_TIME_LIMIT:  r_regs.release_time_limit <= i_cfg.data.data;
                sms_pkg::REG_FAULT_CURRENT_LIMIT: begin
                    r_regs.fault_current_limit <= i_cfg.data.data[11:0];
                end
                sms_pkg::REG_PUSH_MIN_TIME:       r_regs.push_min_time <= i_cfg.data.data;
                sms_pkg::REG_PUSH_EXTRA_TIME:     r_regs.push_extra_time <= i_cfg.data.data;
                sms_pkg::REG_RELEASE_MIN_TIME:    r_regs.release_min_time <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/sms_step.sv =====
module sms_step #(
    parameter int PWM_MAX = 1000,
    parameter int SPD_W   = 10
) (
    input  sms_pkg::t_poll    i_poll,
    input  sms_pkg::t_cfg     i_regs,
    input  sms_pkg::t_state   i_state,
    input  logic [SPD_W-1:0]  i_speed,
    output sms_pkg::t_state   o_state,
    output logic [SPD_W-1:0]  o_speed,
    output sms_pkg::t_result  o_result
);

    localparam logic [15:0]      PWM_MAX_16 = 16'(PWM_MAX);
    localparam logic [SPD_W-1:0] PWM_MAX_S  = SPD_W'(PWM_MAX);

    logic [32:0]       now_x;
    logic [32:0]       push_min_end;
    logic [32:0]       push_limit_end;
    logic [32:0]       extra_end;
    logic [32:0]       rel_min_end;
    logic [32:0]       rel_limit_end;
    logic [SPD_W-1:0]  push_spd;
    logic [SPD_W-1:0]  rel_spd;
    logic [SPD_W-1:0]  duty;
    logic [SPD_W+9:0]  duty_ext;
    logic              safe;
    sms_pkg::t_state   st;
    logic [SPD_W-1:0]  spd;

    // Time sums carry one extra bit so they never wrap
    assign now_x          = {1'b0, i_poll.now_ms};
    assign push_min_end   = {1'b0, i_state.push_start} + {17'd0, i_regs.push_min_time};
    assign push_limit_end = {1'b0, i_state.push_start} + {17'd0, i_regs.push_time_limit};
    assign extra_end      = {1'b0, i_state.sensor_seen_time} + {17'd0, i_regs.push_extra_time};
    assign rel_min_end    = {1'b0, i_state.release_start} + {17'd0, i_regs.release_min_time};
    assign rel_limit_end  = {1'b0, i_state.release_start} + {17'd0, i_regs.release_time_limit};

    assign push_spd = (i_regs.push_speed > PWM_MAX_16) ? PWM_MAX_S
                                                       : SPD_W'(i_regs.push_speed);
    assign rel_spd  = (i_regs.release_speed > PWM_MAX_16) ? PWM_MAX_S
                                                          : SPD_W'(i_regs.release_speed);

    always_comb begin
        st   = i_state;
        spd  = i_speed;
        safe = 1'b0;

        if (i_poll.current_sample > st.peak) begin
            st.peak = i_poll.current_sample;
        end

        if (i_poll.current_sample > i_regs.fault_current_limit
                && st.mode != sms_pkg::MODE_FAULT) begin
            spd      = '0;
            st.power_on = 1'b0;
            st.mode  = sms_pkg::MODE_FAULT;
        end

        if (st.mode == sms_pkg::MODE_PUSHING) begin
            if (!st.sensor_latched) begin
                if (now_x > push_min_end && i_poll.pushed_sensor) begin
                    st.sensor_latched   = 1'b1;
                    st.sensor_seen_time = i_poll.now_ms;
                end else if (push_limit_end < now_x) begin
                    spd         = '0;
                    st.power_on = 1'b0;
                    st.mode     = sms_pkg::MODE_FAULT;
                end
            end else if (now_x > extra_end) begin
                spd         = '0;
                st.power_on = 1'b0;
                st.mode     = sms_pkg::MODE_PUSHED;
            end
        end else if (st.mode == sms_pkg::MODE_RELEASING) begin
            if (now_x > rel_min_end && i_poll.released_sensor) begin
                spd         = '0;
                st.power_on = 1'b0;
                st.mode     = sms_pkg::MODE_RELEASED;
            end
            // timeout wins over the sensor in the same poll
            if (now_x > rel_limit_end) begin
                spd         = '0;
                st.power_on = 1'b0;
                st.mode     = sms_pkg::MODE_FAULT;
            end
        end

        case (i_poll.action)
            sms_pkg::ACT_STOP: begin
                spd         = '0;
                st.power_on = 1'b0;
                st.mode     = sms_pkg::MODE_IDLE;
            end
            sms_pkg::ACT_PUSH: begin
                st.peak = '0;
                if (st.mode != sms_pkg::MODE_FAULT && st.mode != sms_pkg::MODE_PUSHING) begin
                    st.sensor_latched = 1'b0;
                    st.push_start     = i_poll.now_ms;
                    safe              = (st.reverse_dir != sms_pkg::DIR_FWD);
                    st.power_on       = 1'b1;
                    st.reverse_dir    = sms_pkg::DIR_FWD;
                    spd               = push_spd;
                    st.mode           = sms_pkg::MODE_PUSHING;
                end
            end
            sms_pkg::ACT_RELEASE: begin
                st.peak = '0;
                if (st.mode != sms_pkg::MODE_FAULT
                        && st.mode != sms_pkg::MODE_RELEASING) begin
                    st.release_start = i_poll.now_ms;
                    safe             = (st.reverse_dir != sms_pkg::DIR_REV);
                    st.power_on      = 1'b1;
                    st.reverse_dir   = sms_pkg::DIR_REV;
                    spd              = rel_spd;
                    st.mode          = sms_pkg::MODE_RELEASING;
                end
            end
            sms_pkg::ACT_FAULT_RESET: begin
                if (st.mode == sms_pkg::MODE_FAULT) begin
                    spd         = '0;
                    st.power_on = 1'b0;
                    st.peak     = '0;
                    st.mode     = sms_pkg::MODE_IDLE;
                end
            end
            default: ;
        endcase
    end

    // speed never exceeds PWM_MAX, so the reverse duty cannot underflow
    assign duty     = !st.power_on ? '0
                    : (st.reverse_dir ? (PWM_MAX_S - spd) : spd);
    assign duty_ext = {10'd0, duty};

    assign o_state  = st;
    assign o_speed  = spd;

    assign o_result.status        = st.mode;
    assign o_result.power_enable  = st.power_on;
    assign o_result.in1_high_duty = duty_ext[9:0];
    assign o_result.in2_level     = st.power_on & st.reverse_dir;
    assign o_result.safe_phase    = safe;
    assign o_result.peak_current  = st.peak;

endmodule

// ===== hw/rtl/seal_motor_sequencer.sv =====
// Channel   Dir  Word       Fields
// i_poll    in   t_poll     action, now_ms, pushed_sensor, released_sensor, current_sample
// o_result  out  t_result   status, power_enable, in1_high_duty, in2_level,
//                           safe_phase, peak_current
// i_cfg     in   t_cfg_wr   index (0..7), data (16 bits, limit register takes [11:0])
//
// One poll word per cycle while the result is not stalled. An accepted poll
// goes to a poll register, then through the step logic into the result register.
// The step logic is the longest path: a 33-bit start-plus-span add and compare.
// i_rst_n is synchronous, active low; it clears both stages and the sequencer
// state and restores the register defaults. A stalled result holds while the
// poll register keeps accepting until it too is full.
module seal_motor_sequencer #(
    parameter int PWM_MAX = 1000
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sms_chan_if.sink  i_poll,
    sms_chan_if.sink  i_cfg,
    sms_chan_if.source o_result
);

    localparam int SPD_W = $clog2(PWM_MAX + 1);

    sms_pkg::t_cfg    regs;

    // poll stage
    sms_pkg::t_poll   r_poll;
    logic             r_poll_valid;

    // result stage
    sms_pkg::t_result r_result;
    logic             r_result_valid;
    sms_pkg::t_result n_result;

    // sequencer state
    sms_pkg::t_state  r_state;
    sms_pkg::t_state  n_state;
    logic [SPD_W-1:0] r_speed;
    logic [SPD_W-1:0] n_speed;

    logic             advance;

    sms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (regs)
    );

    sms_step #(
        .PWM_MAX (PWM_MAX),
        .SPD_W   (SPD_W)
    ) u_step (
        .i_poll   (r_poll),
        .i_regs   (regs),
        .i_state  (r_state),
        .i_speed  (r_speed),
        .o_state  (n_state),
        .o_speed  (n_speed),
        .o_result (n_result)
    );

    // Advance the held poll whenever the result register is free or draining
    assign advance      = r_poll_valid && (!r_result_valid || o_result.ready);
    assign i_poll.ready = !r_poll_valid || advance;

    assign o_result.valid = r_result_valid;
    assign o_result.data  = r_result;

    // Poll register: load on accept, drop once passed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_valid <= 1'b0;
        end else if (i_poll.valid && i_poll.ready) begin
            r_poll_valid <= 1'b1;
        end else if (advance) begin
            r_poll_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_poll.valid && i_poll.ready) begin
            r_poll <= i_poll.data;
        end
    end

    // Result register and state commit together, one poll at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
            r_state        <= '{mode:             sms_pkg::MODE_IDLE,
                                sensor_latched:   1'b0,
                                push_start:       32'd0,
                                sensor_seen_time: 32'd0,
                                release_start:    32'd0,
                                peak:             12'd0,
                                reverse_dir:      sms_pkg::DIR_FWD,
                                power_on:         1'b0};
            r_speed        <= '0;
        end else if (advance) begin
            r_result_valid <= 1'b1;
            r_state        <= n_state;
            r_speed        <= n_speed;
        end else if (o_result.ready) begin
            r_result_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

endmodule

// ===== hw/rtl/sms_check.sv =====
module sms_check (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input sms_pkg::t_result i_out_data
);

    // a stalled result word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result word changed");

    // reset empties the result stage
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // the bridge is never powered outside a driving status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.power_enable |->
            (i_out_data.status == sms_pkg::MODE_PUSHING
             || i_out_data.status == sms_pkg::MODE_RELEASING))
        else $error("power on outside push or release");

    // unpowered bridge shows no drive
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.power_enable |->
            i_out_data.in1_high_duty == 10'd0 && !i_out_data.in2_level
            && !i_out_data.safe_phase)
        else $error("drive shown while unpowered");

    // reverse level only while releasing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.in2_level |->
            i_out_data.status == sms_pkg::MODE_RELEASING)
        else $error("reverse level outside release");

endmodule

bind seal_motor_sequencer sms_check u_sms_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

// ===== tb/tb_seal_motor_sequencer.sv =====
`timescale 1ns / 100ps

module tb_seal_motor_sequencer;

    localparam int PWM_MAX      = 1000;
    localparam int IDLE_PCT     = 26;      // percent of cycles each side sits out
    localparam int STALL_LIMIT  = 4000;    // cycles with no word moving anywhere
    localparam int RANDOM_POLLS = 1450;
    localparam int PHASE_POLLS  = 150;
    localparam logic [2:0] ACT_UNDEFINED = 3'd7;

    // One row of the directed script: the poll word and, where it is obvious,
    // the result word typed in by hand.
    typedef struct {
        sms_pkg::t_poll   word;
        bit               known;
        sms_pkg::t_result want;
    } t_script_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sms_chan_if #(.T_DATA(sms_pkg::t_poll))   poll_if ();
    sms_chan_if #(.T_DATA(sms_pkg::t_cfg_wr)) cfg_if ();
    sms_chan_if #(.T_DATA(sms_pkg::t_result)) res_if ();

    seal_motor_sequencer #(.PWM_MAX(PWM_MAX)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_poll   (poll_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Sequencer state as the testbench sees it, advanced once per accepted poll.
    sms_pkg::t_cfg   regs;
    sms_pkg::t_state sq;
    logic [9:0]      sq_speed;

    sms_pkg::t_result pending_outputs[$];
    t_script_row      script[$];

    int          errors     = 0;
    int          items_sent = 0;
    bit          calm       = 1'b0;   // set: neither side idles
    int unsigned step_max   = 25;     // largest time advance between polls, ms
    logic [31:0] t_ms       = 32'd0;  // running poll timestamp

    function automatic void motor_off();
        sq.power_on = 1'b0;
        sq_speed    = '0;
    endfunction

    // Start a drive; report whether the direction changed.
    function automatic logic motor_on(input logic dir, input logic [15:0] speed);
        logic changed;
        changed         = (dir != sq.reverse_dir);
        sq.power_on     = 1'b1;
        sq.reverse_dir  = dir;
        sq_speed        = (speed > 16'(PWM_MAX)) ? 10'(PWM_MAX) : speed[9:0];
        return changed;
    endfunction

    // Work out the result word of one poll and advance the sequencer state.
    function automatic sms_pkg::t_result predict_outputs(input sms_pkg::t_poll p);
        sms_pkg::t_result r;
        logic [32:0]      t;
        logic             safe;
        int               duty;
        t    = {1'b0, p.now_ms};
        safe = 1'b0;
        duty = 0;
        r    = '0;

        // Peak first, then the over-current trip.
        if (p.current_sample > sq.peak)
            sq.peak = p.current_sample;
        if (p.current_sample > regs.fault_current_limit
                && sq.mode != sms_pkg::MODE_FAULT) begin
            motor_off();
            sq.mode = sms_pkg::MODE_FAULT;
        end

        // Advance the sequence; start plus span is 33 bits wide, so it never wraps.
        if (sq.mode == sms_pkg::MODE_PUSHING) begin
            if (!sq.sensor_latched) begin
                if (t > {1'b0, sq.push_start} + 33'(regs.push_min_time) && p.pushed_sensor) begin
                    sq.sensor_latched   = 1'b1;
                    sq.sensor_seen_time = p.now_ms;
                end else if ({1'b0, sq.push_start} + 33'(regs.push_time_limit) < t) begin
                    motor_off();
                    sq.mode = sms_pkg::MODE_FAULT;
                end
            end else if (t > {1'b0, sq.sensor_seen_time} + 33'(regs.push_extra_time)) begin
                motor_off();
                sq.mode = sms_pkg::MODE_PUSHED;
            end
        end else if (sq.mode == sms_pkg::MODE_RELEASING) begin
            if (t > {1'b0, sq.release_start} + 33'(regs.release_min_time)
                    && p.released_sensor) begin
                motor_off();
                sq.mode = sms_pkg::MODE_RELEASED;
            end
            // The timeout wins over a release finished in the same poll.
            if (t > {1'b0, sq.release_start} + 33'(regs.release_time_limit)) begin
                motor_off();
                sq.mode = sms_pkg::MODE_FAULT;
            end
        end

        case (p.action)
            sms_pkg::ACT_STOP: begin
                motor_off();
                sq.mode = sms_pkg::MODE_IDLE;
            end
            sms_pkg::ACT_PUSH: begin
                sq.peak = '0;
                if (sq.mode != sms_pkg::MODE_FAULT && sq.mode != sms_pkg::MODE_PUSHING) begin
                    sq.sensor_latched = 1'b0;
                    sq.push_start     = p.now_ms;
                    safe              = motor_on(sms_pkg::DIR_FWD, regs.push_speed);
                    sq.mode           = sms_pkg::MODE_PUSHING;
                end
            end
            sms_pkg::ACT_RELEASE: begin
                sq.peak = '0;
                if (sq.mode != sms_pkg::MODE_FAULT
                        && sq.mode != sms_pkg::MODE_RELEASING) begin
                    sq.release_start = p.now_ms;
                    safe             = motor_on(sms_pkg::DIR_REV, regs.release_speed);
                    sq.mode          = sms_pkg::MODE_RELEASING;
                end
            end
            sms_pkg::ACT_FAULT_RESET: begin
                if (sq.mode == sms_pkg::MODE_FAULT) begin
                    motor_off();
                    sq.peak = '0;
                    sq.mode = sms_pkg::MODE_IDLE;
                end
            end
            default: ;
        endcase

        // Unpowered bridge shows zero duty and IN2 low.
        if (sq.power_on) begin
            r.in2_level = sq.reverse_dir;
            duty = sq.reverse_dir ? PWM_MAX - int'(sq_speed) : int'(sq_speed);
        end
        r.status        = sq.mode;
        r.power_enable  = sq.power_on;
        r.in1_high_duty = 10'(duty);
        r.safe_phase    = safe;
        r.peak_current  = sq.peak;
        return r;
    endfunction

    function automatic sms_pkg::t_poll poll_word(input logic [2:0] act,
                                                 input logic [31:0] now,
                                                 input logic ps, input logic rs,
                                                 input logic [11:0] cur);
        sms_pkg::t_poll p;
        p.action          = act;
        p.now_ms          = now;
        p.pushed_sensor   = ps;
        p.released_sensor = rs;
        p.current_sample  = cur;
        return p;
    endfunction

    function automatic sms_pkg::t_result result_word(input logic [2:0] st, input logic pwr,
                                                     input logic [9:0] duty,
                                                     input logic in2, input logic safe,
                                                     input logic [11:0] pk);
        sms_pkg::t_result r;
        r.status        = st;
        r.power_enable  = pwr;
        r.in1_high_duty = duty;
        r.in2_level     = in2;
        r.safe_phase    = safe;
        r.peak_current  = pk;
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Offer one poll word, idling at random first; queue its result on acceptance.
    task automatic send_poll(input sms_pkg::t_poll p, input bit known,
                             input sms_pkg::t_result want);
        sms_pkg::t_result pred;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            poll_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        poll_if.valid <= 1'b1;
        poll_if.data  <= p;
        @(posedge i_clk);
        while (!poll_if.ready)
            @(posedge i_clk);
        pred = predict_outputs(p);
        pending_outputs.push_back(known ? want : pred);
        items_sent++;
        // Hold a long stretch with both sides running flat out.
        calm = (items_sent >= 500 && items_sent < 700);
    endtask

    // Advance the clock of the poll stream and send one poll with a fresh current.
    task automatic put(input logic [2:0] act, input logic ps, input logic rs);
        logic [11:0] cur;
        t_ms = t_ms + 32'($urandom_range(0, step_max));
        if ($urandom_range(0, 299) == 0)
            t_ms = 32'hFFFF_0000 | 32'($urandom_range(0, 65535));
        if ($urandom_range(0, 99) < 93)
            cur = 12'($urandom_range(0, int'(regs.fault_current_limit)));
        else
            cur = 12'($urandom());
        send_poll(poll_word(act, t_ms, ps, rs, cur), 1'b0, '0);
    endtask

    // One push then release with random timing and sensor onset.
    task automatic run_cycle();
        int n;
        int k;
        logic ps;
        logic rs;
        logic [2:0] act;
        put(sms_pkg::ACT_PUSH, 1'b0, 1'b0);
        n = $urandom_range(3, 24);
        k = $urandom_range(0, n);
        for (int i = 0; i < n; i++) begin
            ps  = (i >= k);
            rs  = ($urandom_range(0, 3) == 0) ? 1'($urandom()) : ps;
            act = ($urandom_range(0, 19) == 0) ? 3'($urandom()) : sms_pkg::ACT_NONE;
            put(act, ps, rs);
        end
        if ($urandom_range(0, 4) == 0)
            put(sms_pkg::ACT_STOP, 1'b1, 1'b1);
        put(sms_pkg::ACT_RELEASE, 1'b1, 1'b0);
        n = $urandom_range(3, 24);
        k = $urandom_range(0, n);
        for (int i = 0; i < n; i++) begin
            rs  = (i >= k);
            ps  = ($urandom_range(0, 3) == 0) ? 1'($urandom()) : rs;
            act = ($urandom_range(0, 19) == 0) ? 3'($urandom()) : sms_pkg::ACT_NONE;
            put(act, ps, rs);
        end
        if (sq.mode == sms_pkg::MODE_FAULT && $urandom_range(0, 3) != 0)
            put(sms_pkg::ACT_FAULT_RESET, 1'b0, 1'b0);
        else if ($urandom_range(0, 4) == 0)
            put(sms_pkg::ACT_STOP, 1'b0, 1'b0);
    endtask

    // Write one register word; mirror it into the predictor on acceptance.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            cfg_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, data: val};
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        case (idx)
            sms_pkg::REG_PUSH_SPEED:          regs.push_speed          = val;
            sms_pkg::REG_RELEASE_SPEED:       regs.release_speed       = val;
            sms_pkg::REG_PUSH_TIME_LIMIT:     regs.push_time_limit     = val;
            sms_pkg::REG_RELEASE_TIME_LIMIT:  regs.release_time_limit  = val;
            sms_pkg::REG_FAULT_CURRENT_LIMIT: regs.fault_current_limit = val[11:0];
            sms_pkg::REG_PUSH_MIN_TIME:       regs.push_min_time       = val;
            sms_pkg::REG_PUSH_EXTRA_TIME:     regs.push_extra_time     = val;
            sms_pkg::REG_RELEASE_MIN_TIME:    regs.release_min_time    = val;
            default: ;
        endcase
    endtask

    // Result side: random back-pressure.
    always @(posedge i_clk) begin
        res_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each result word with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        sms_pkg::t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_outputs.size() == 0) begin
                $error("result word with no poll waiting for it");
                errors++;
            end else begin
                want = pending_outputs.pop_front();
                check_field("status", want.status, res_if.data.status);
                check_field("power_enable", want.power_enable, res_if.data.power_enable);
                check_field("in1_high_duty", want.in1_high_duty, res_if.data.in1_high_duty);
                check_field("in2_level", want.in2_level, res_if.data.in2_level);
                check_field("safe_phase", want.safe_phase, res_if.data.safe_phase);
                check_field("peak_current", want.peak_current, res_if.data.peak_current);
            end
        end
    end

    // Watchdog: end the run when nothing has moved for too long.
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((poll_if.valid && poll_if.ready) || (cfg_if.valid && cfg_if.ready)
                || (res_if.valid && res_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] vals [8];
        int          phase;
        int          phase_end;
        int          total;

        i_rst_n       = 1'b0;
        poll_if.valid = 1'b0;
        poll_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;

        // Register defaults and cleared state, as after reset.
        regs.push_speed          = 16'd500;
        regs.release_speed       = 16'd500;
        regs.push_time_limit     = 16'd5000;
        regs.release_time_limit  = 16'd5000;
        regs.fault_current_limit = 12'd4095;
        regs.push_min_time       = 16'd200;
        regs.push_extra_time     = 16'd300;
        regs.release_min_time    = 16'd200;
        sq       = '0;
        sq_speed = '0;

        // Directed script, default registers.
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd0, 1'b0, 1'b0, 12'd0), 1'b1,
            result_word(sms_pkg::MODE_IDLE, 1'b0, 10'd0, 1'b0, 1'b0, 12'd0)});
        // Full-scale sample equal to the limit: peak only, no trip.
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd1, 1'b0, 1'b0, 12'd4095), 1'b1,
            result_word(sms_pkg::MODE_IDLE, 1'b0, 10'd0, 1'b0, 1'b0, 12'd4095)});
        script.push_back('{poll_word(sms_pkg::ACT_PUSH, 32'd10, 1'b0, 1'b0, 12'd0), 1'b1,
            result_word(sms_pkg::MODE_PUSHING, 1'b1, 10'd500, 1'b0, 1'b0, 12'd0)});
        // Push while pushing: clear the peak only.
        script.push_back('{poll_word(sms_pkg::ACT_PUSH, 32'd20, 1'b0, 1'b0, 12'd7), 1'b0, '0});
        // Sensor exactly at the minimum time, then one past it.
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd210, 1'b1, 1'b1, 12'd0), 1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd211, 1'b1, 1'b1, 12'd0), 1'b0, '0});
        // Extra drive time: boundary, then done.
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd511, 1'b1, 1'b1, 12'd0), 1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd512, 1'b1, 1'b1, 12'd0), 1'b0, '0});
        // Release reverses: duty is max minus speed, IN2 high, safe phase shown.
        script.push_back('{poll_word(sms_pkg::ACT_RELEASE, 32'd600, 1'b0, 1'b0, 12'd0), 1'b1,
            result_word(sms_pkg::MODE_RELEASING, 1'b1, 10'd500, 1'b1, 1'b1, 12'd0)});
        script.push_back('{poll_word(sms_pkg::ACT_RELEASE, 32'd601, 1'b0, 1'b0, 12'd9),
            1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd800, 1'b0, 1'b1, 12'd3), 1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd801, 1'b0, 1'b1, 12'd0), 1'b0, '0});
        // Same direction again: no safe phase.
        script.push_back('{poll_word(sms_pkg::ACT_RELEASE, 32'd900, 1'b0, 1'b0, 12'd0),
            1'b0, '0});
        // Release done and release timeout in the same poll: fault wins.
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd5901, 1'b1, 1'b1, 12'd0),
            1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_PUSH, 32'd5902, 1'b0, 1'b0, 12'd5), 1'b1,
            result_word(sms_pkg::MODE_FAULT, 1'b0, 10'd0, 1'b0, 1'b0, 12'd0)});
        script.push_back('{poll_word(sms_pkg::ACT_RELEASE, 32'd5903, 1'b0, 1'b0, 12'd6),
            1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_FAULT_RESET, 32'd5904, 1'b0, 1'b0, 12'd0),
            1'b1, result_word(sms_pkg::MODE_IDLE, 1'b0, 10'd0, 1'b0, 1'b0, 12'd0)});
        // Fault reset when not faulted does nothing.
        script.push_back('{poll_word(sms_pkg::ACT_FAULT_RESET, 32'd5905, 1'b0, 1'b0, 12'd8),
            1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_PUSH, 32'd6000, 1'b0, 1'b0, 12'd0),
            1'b0, '0});
        // Push timeout: boundary, then fault.
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd11000, 1'b0, 1'b0, 12'd0),
            1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'd11001, 1'b0, 1'b0, 12'd0),
            1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_FAULT_RESET, 32'd11002, 1'b0, 1'b0, 12'd0),
            1'b0, '0});
        // Start near the top of the timestamp range: the limit sum must not wrap.
        script.push_back('{poll_word(sms_pkg::ACT_PUSH, 32'hFFFF_FF00, 1'b0, 1'b0, 12'd0),
            1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_NONE, 32'hFFFF_FFFF, 1'b0, 1'b0, 12'd4095),
            1'b0, '0});
        script.push_back('{poll_word(sms_pkg::ACT_STOP, 32'hFFFF_FFFF, 1'b1, 1'b1, 12'd0),
            1'b0, '0});
        script.push_back('{poll_word(ACT_UNDEFINED, 32'd12, 1'b1, 1'b0, 12'd2), 1'b0, '0});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i])
            send_poll(script[i].word, script[i].known, script[i].want);

        total = items_sent + RANDOM_POLLS;
        phase = 0;
        while (items_sent < total) begin
            // Drain, let the pipeline settle, then reprogram every register.
            poll_if.valid <= 1'b0;
            while (pending_outputs.size() != 0)
                @(posedge i_clk);
            repeat (4) @(posedge i_clk);

            case (phase % 5)
                0: begin
                    vals[sms_pkg::REG_PUSH_SPEED]         = 16'($urandom_range(0, PWM_MAX));
                    vals[sms_pkg::REG_RELEASE_SPEED]      = 16'($urandom_range(0, PWM_MAX));
                    vals[sms_pkg::REG_PUSH_TIME_LIMIT]    = 16'($urandom_range(0, 400));
                    vals[sms_pkg::REG_RELEASE_TIME_LIMIT] = 16'($urandom_range(0, 400));
                    vals[sms_pkg::REG_FAULT_CURRENT_LIMIT] =
                        16'($urandom_range(3000, 4095));
                    vals[sms_pkg::REG_PUSH_MIN_TIME]      = 16'($urandom_range(0, 100));
                    vals[sms_pkg::REG_PUSH_EXTRA_TIME]    = 16'($urandom_range(0, 100));
                    vals[sms_pkg::REG_RELEASE_MIN_TIME]   = 16'($urandom_range(0, 100));
                    step_max = 25;
                end
                1: begin
                    foreach (vals[i])
                        vals[i] = 16'h0000;
                    step_max = 2;
                end
                2: begin
                    foreach (vals[i])
                        vals[i] = 16'hFFFF;
                    step_max = 12000;
                end
                3: begin
                    // Speeds above the PWM maximum, limit with random upper bits.
                    vals[sms_pkg::REG_PUSH_SPEED]    = 16'($urandom_range(PWM_MAX + 1, 65535));
                    vals[sms_pkg::REG_RELEASE_SPEED] = 16'($urandom_range(PWM_MAX + 1, 65535));
                    vals[sms_pkg::REG_PUSH_TIME_LIMIT]    = 16'($urandom_range(0, 1200));
                    vals[sms_pkg::REG_RELEASE_TIME_LIMIT] = 16'($urandom_range(0, 1200));
                    vals[sms_pkg::REG_FAULT_CURRENT_LIMIT] = 16'($urandom_range(0, 65535));
                    vals[sms_pkg::REG_PUSH_MIN_TIME]      = 16'($urandom_range(0, 300));
                    vals[sms_pkg::REG_PUSH_EXTRA_TIME]    = 16'($urandom_range(0, 300));
                    vals[sms_pkg::REG_RELEASE_MIN_TIME]   = 16'($urandom_range(0, 300));
                    step_max = 60;
                end
                default: begin
                    vals[sms_pkg::REG_PUSH_SPEED]         = 16'(PWM_MAX);
                    vals[sms_pkg::REG_RELEASE_SPEED]      = 16'($urandom_range(0, 1));
                    vals[sms_pkg::REG_PUSH_TIME_LIMIT]    = 16'($urandom_range(500, 4000));
                    vals[sms_pkg::REG_RELEASE_TIME_LIMIT] = 16'($urandom_range(500, 4000));
                    vals[sms_pkg::REG_FAULT_CURRENT_LIMIT] = 16'd4095;
                    vals[sms_pkg::REG_PUSH_MIN_TIME]      = 16'($urandom_range(0, 1000));
                    vals[sms_pkg::REG_PUSH_EXTRA_TIME]    = 16'($urandom_range(0, 1000));
                    vals[sms_pkg::REG_RELEASE_MIN_TIME]   = 16'($urandom_range(0, 1000));
                    step_max = 150;
                end
            endcase
            for (int r = sms_pkg::REG_PUSH_SPEED; r <= sms_pkg::REG_RELEASE_MIN_TIME; r++)
                write_reg(3'(r), vals[r]);
            cfg_if.valid <= 1'b0;

            // Mostly whole push/release cycles; the rest is noise.
            phase_end = items_sent + PHASE_POLLS;
            while (items_sent < phase_end && items_sent < total) begin
                if ($urandom_range(0, 99) < 75) begin
                    run_cycle();
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 9) == 0)
                            t_ms = $urandom();
                        put(3'($urandom()), 1'($urandom()), 1'($urandom()));
                    end
                end
            end
            phase++;
        end

        // Drop valid, drain, and give the pipeline a few cycles to misbehave.
        poll_if.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
